// File: sv/tfn_pkg.sv
package tfn_pkg;

    // magnitudes are normalized so the largest has this many bits
    localparam int NORM_BITS = 20;
    // fraction bits of the length
    localparam int LEN_FRAC = 11;
    // depth of the queue between front and back
    localparam int QDEPTH = 4;

    typedef struct packed {
        logic [NORM_BITS-1:0] ax;
        logic [NORM_BITS-1:0] ay;
        logic [NORM_BITS-1:0] az;
        logic [2:0]           neg;
        logic                 deg;
    } t_cls;

    typedef struct packed {
        logic push;
        logic pop;
    } t_qctl;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qsts;

endpackage

// File: sv/tfn_if.sv
interface tfn_in_if #(parameter int W = 16);
    logic valid;
    logic ready;
    logic signed [W-1:0] first_x;
    logic signed [W-1:0] first_y;
    logic signed [W-1:0] first_z;
    logic signed [W-1:0] second_x;
    logic signed [W-1:0] second_y;
    logic signed [W-1:0] second_z;
    logic signed [W-1:0] third_x;
    logic signed [W-1:0] third_y;
    logic signed [W-1:0] third_z;
    modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                    third_x, third_y, third_z, input ready);
    modport sink (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                  third_x, third_y, third_z, output ready);
endinterface

interface tfn_out_if #(parameter int W = 16);
    logic valid;
    logic ready;
    logic signed [W-1:0] normal_x;
    logic signed [W-1:0] normal_y;
    logic signed [W-1:0] normal_z;
    logic degenerate;
    modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
    modport sink (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

// File: sv/tfn_front.sv
module tfn_front #(
    parameter int COORD_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tfn_in_if.sink        i_tri,
    input  tfn_pkg::t_qsts i_qsts,
    output logic          o_push,
    output tfn_pkg::t_cls o_cls
);
    import tfn_pkg::*;

    localparam int EW = COORD_BITS + 1;
    localparam int PW = 2 * EW;
    localparam int NW = PW + 1;
    localparam int BW = $clog2(NW + 1);
    localparam int SW = NW + NORM_BITS;

    logic [6:0] r_vld;
    logic       w_en;

    logic signed [COORD_BITS-1:0] r_vtx [9];
    logic signed [EW-1:0] r_e1 [3];
    logic signed [EW-1:0] r_e2 [3];
    logic signed [PW-1:0] r_p [6];
    logic signed [NW-1:0] r_n [3];
    logic [NW-1:0]        r_m4 [3];
    logic [2:0]           r_neg4;
    logic [NW-1:0]        r_m5 [3];
    logic [2:0]           r_neg5;
    logic [BW-1:0]        r_b;
    logic [BW-1:0]        n_b;
    logic [NW-1:0]        w_or;
    t_cls                 r_cls;
    t_cls                 n_cls;
    logic [SW-1:0]        w_sh [3];

    assign w_en = !r_vld[6] || !i_qsts.full;
    assign i_tri.ready = w_en;
    assign o_push = r_vld[6] && !i_qsts.full;
    assign o_cls = r_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[5:0], i_tri.valid};
        end
    end

    // leading one of the widest magnitude, registered beside the magnitudes
    assign w_or = r_m4[0] | r_m4[1] | r_m4[2];
    always_comb begin
        n_b = '0;
        for (int i = 0; i < NW; i++) begin
            if (w_or[i]) n_b = BW'(i + 1);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sh[i] = {r_m5[i], {NORM_BITS{1'b0}}} >> r_b;
        end
        n_cls.ax  = w_sh[0][NORM_BITS-1:0];
        n_cls.ay  = w_sh[1][NORM_BITS-1:0];
        n_cls.az  = w_sh[2][NORM_BITS-1:0];
        n_cls.neg = r_neg5;
        n_cls.deg = (r_b == '0);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_vtx[0] <= i_tri.first_x;
            r_vtx[1] <= i_tri.first_y;
            r_vtx[2] <= i_tri.first_z;
            r_vtx[3] <= i_tri.second_x;
            r_vtx[4] <= i_tri.second_y;
            r_vtx[5] <= i_tri.second_z;
            r_vtx[6] <= i_tri.third_x;
            r_vtx[7] <= i_tri.third_y;
            r_vtx[8] <= i_tri.third_z;
            for (int i = 0; i < 3; i++) begin
                r_e1[i] <= EW'(r_vtx[3+i]) - EW'(r_vtx[i]);
                r_e2[i] <= EW'(r_vtx[6+i]) - EW'(r_vtx[i]);
            end
            r_p[0] <= PW'(r_e2[1]) * PW'(r_e1[2]);
            r_p[1] <= PW'(r_e2[2]) * PW'(r_e1[1]);
            r_p[2] <= PW'(r_e2[2]) * PW'(r_e1[0]);
            r_p[3] <= PW'(r_e2[0]) * PW'(r_e1[2]);
            r_p[4] <= PW'(r_e2[0]) * PW'(r_e1[1]);
            r_p[5] <= PW'(r_e2[1]) * PW'(r_e1[0]);
            for (int i = 0; i < 3; i++) begin
                r_n[i] <= NW'(r_p[2*i]) - NW'(r_p[2*i+1]);
                r_m4[i] <= r_n[i][NW-1] ? NW'(-r_n[i]) : NW'(r_n[i]);
                r_neg4[i] <= r_n[i][NW-1];
            end
            r_m5   <= r_m4;
            r_neg5 <= r_neg4;
            r_b    <= n_b;
            r_cls  <= n_cls;
        end
    end

endmodule

// File: sv/tfn_queue.sv
module tfn_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tfn_pkg::t_qctl i_qctl,
    input  tfn_pkg::t_cls  i_cls,
    output tfn_pkg::t_cls  o_cls,
    output tfn_pkg::t_qsts o_qsts
);
    import tfn_pkg::*;

    localparam int AW = $clog2(QDEPTH);
    localparam int CW = $clog2(QDEPTH + 1);

    t_cls          r_mem [QDEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    assign o_qsts.full  = (r_cnt == CW'(QDEPTH));
    assign o_qsts.empty = (r_cnt == '0);
    assign o_cls = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_qctl.push) r_wr <= r_wr + 1'b1;
            if (i_qctl.pop)  r_rd <= r_rd + 1'b1;
            if (i_qctl.push && !i_qctl.pop) r_cnt <= r_cnt + 1'b1;
            else if (!i_qctl.push && i_qctl.pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_qctl.push) r_mem[r_wr] <= i_cls;
    end

endmodule

// File: sv/tfn_back.sv
module tfn_back #(
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tfn_pkg::t_cls i_cls,
    input  logic          i_empty,
    output logic          o_pop,
    tfn_out_if.source     o_nrm
);
    import tfn_pkg::*;

    localparam int SS = 2 * NORM_BITS + 2;
    localparam int LW = 2 * (NORM_BITS + 1 + LEN_FRAC);
    localparam int SQ = LW / 2;
    localparam int RW = SQ;
    localparam int QW = NORMAL_FRAC_BITS + 1;
    localparam int OW = NORMAL_FRAC_BITS + 2;
    localparam int DW = NORM_BITS + NORMAL_FRAC_BITS + LEN_FRAC + 1;
    localparam int CW = (DW > RW + QW) ? DW : RW + QW;

    logic w_en;
    logic r_v0, r_v1, r_v2;
    t_cls r_c0, r_c1, r_c2;
    logic [2*NORM_BITS-1:0] r_sq [3];
    logic [SS-1:0] r_l2;

    logic          r_sv [SQ+1];
    t_cls          r_sc [SQ+1];
    logic [LW-1:0] r_st [SQ+1];
    logic [LW-1:0] r_sr [SQ+1];

    logic          r_dv [QW+1];
    t_cls          r_dc [QW+1];
    logic [RW-1:0] r_dr [QW+1];
    logic [CW-1:0] r_rem [QW+1][3];
    logic [QW-1:0] r_q [QW+1][3];

    logic                 r_ovld;
    logic signed [OW-1:0] r_nx, r_ny, r_nz;
    logic                 r_deg;
    logic signed [OW-1:0] n_nv [3];
    logic [QW-1:0]        w_sat [3];
    logic [RW-1:0]        w_root;

    assign w_en  = !r_ovld || o_nrm.ready;
    assign o_pop = !i_empty && w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= o_pop;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c0 <= i_cls;
            r_c1 <= r_c0;
            r_sq[0] <= r_c0.ax * r_c0.ax;
            r_sq[1] <= r_c0.ay * r_c0.ay;
            r_sq[2] <= r_c0.az * r_c0.az;
            r_c2 <= r_c1;
            r_l2 <= SS'(r_sq[0]) + SS'(r_sq[1]) + SS'(r_sq[2]);
        end
    end

    // digit-by-digit square root, one result bit per stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (w_en) begin
            r_sv[0] <= r_v2;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sc[0] <= r_c2;
            r_st[0] <= LW'(r_l2) << (2 * LEN_FRAC);
            r_sr[0] <= '0;
        end
    end

    for (genvar s = 0; s < SQ; s++) begin : g_sqrt
        localparam logic [LW-1:0] SBIT = {{(LW-1){1'b0}}, 1'b1} << (2 * (SQ - 1 - s));
        logic [LW-1:0] w_sum;
        logic          w_ge;
        assign w_sum = r_sr[s] + SBIT;
        assign w_ge  = (r_st[s] >= w_sum);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[s+1] <= 1'b0;
            end else if (w_en) begin
                r_sv[s+1] <= r_sv[s];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sc[s+1] <= r_sc[s];
                r_st[s+1] <= w_ge ? r_st[s] - w_sum : r_st[s];
                r_sr[s+1] <= w_ge ? (r_sr[s] >> 1) + SBIT : r_sr[s] >> 1;
            end
        end
    end

    // rounded numerators, then restoring division one quotient bit per stage
    assign w_root = r_sr[SQ][RW-1:0];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (w_en) begin
            r_dv[0] <= r_sv[SQ];
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dc[0] <= r_sc[SQ];
            r_dr[0] <= w_root;
            r_rem[0][0] <= (CW'(r_sc[SQ].ax) << (NORMAL_FRAC_BITS + LEN_FRAC))
                           + CW'(w_root >> 1);
            r_rem[0][1] <= (CW'(r_sc[SQ].ay) << (NORMAL_FRAC_BITS + LEN_FRAC))
                           + CW'(w_root >> 1);
            r_rem[0][2] <= (CW'(r_sc[SQ].az) << (NORMAL_FRAC_BITS + LEN_FRAC))
                           + CW'(w_root >> 1);
            for (int c = 0; c < 3; c++) r_q[0][c] <= '0;
        end
    end

    for (genvar d = 0; d < QW; d++) begin : g_div
        logic [CW-1:0] w_dsh;
        assign w_dsh = CW'(r_dr[d]) << (QW - 1 - d);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[d+1] <= 1'b0;
            end else if (w_en) begin
                r_dv[d+1] <= r_dv[d];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dc[d+1] <= r_dc[d];
                r_dr[d+1] <= r_dr[d];
                for (int c = 0; c < 3; c++) begin
                    if (r_rem[d][c] >= w_dsh) begin
                        r_rem[d+1][c] <= r_rem[d][c] - w_dsh;
                        r_q[d+1][c]   <= r_q[d][c] | (QW'(1) << (QW - 1 - d));
                    end else begin
                        r_rem[d+1][c] <= r_rem[d][c];
                        r_q[d+1][c]   <= r_q[d][c];
                    end
                end
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_sat[c] = (r_q[QW][c] > (QW'(1) << NORMAL_FRAC_BITS))
                       ? (QW'(1) << NORMAL_FRAC_BITS) : r_q[QW][c];
            if (r_dc[QW].deg) n_nv[c] = '0;
            else if (r_dc[QW].neg[c]) n_nv[c] = -OW'(w_sat[c]);
            else n_nv[c] = OW'(w_sat[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_ovld <= r_dv[QW];
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_nx  <= n_nv[0];
            r_ny  <= n_nv[1];
            r_nz  <= n_nv[2];
            r_deg <= r_dc[QW].deg;
        end
    end

    assign o_nrm.valid      = r_ovld;
    assign o_nrm.normal_x   = r_nx;
    assign o_nrm.normal_y   = r_ny;
    assign o_nrm.normal_z   = r_nz;
    assign o_nrm.degenerate = r_deg;

endmodule

// File: sv/triangle_face_normal.sv
// pipeline: 7 front stages, the queue, then 3 + 33 square-root stages and
// NORMAL_FRAC_BITS + 3 divide/output stages
// throughput: one triangle per cycle while the output takes results; the square root and
// dividers are fully pipelined, one result bit per stage
// reset: synchronous active low, clears all valid bits and the queue; data regs keep value
module triangle_face_normal #(
    parameter int COORD_BITS       = 16,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tfn_in_if.sink     i_tri,
    tfn_out_if.source  o_nrm
);
    import tfn_pkg::*;

    t_cls  w_fcls;
    t_cls  w_qcls;
    t_qctl w_qctl;
    t_qsts w_qsts;
    logic  w_push;
    logic  w_pop;

    assign w_qctl.push = w_push;
    assign w_qctl.pop  = w_pop;

    tfn_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tri   (i_tri),
        .i_qsts  (w_qsts),
        .o_push  (w_push),
        .o_cls   (w_fcls)
    );

    tfn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qctl  (w_qctl),
        .i_cls   (w_fcls),
        .o_cls   (w_qcls),
        .o_qsts  (w_qsts)
    );

    tfn_back #(.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cls   (w_qcls),
        .i_empty (w_qsts.empty),
        .o_pop   (w_pop),
        .o_nrm   (o_nrm)
    );

endmodule

// File: bench/tb_triangle_face_normal.sv
module tb_triangle_face_normal;
    import tfn_pkg::*;

    typedef logic signed [15:0] t_coords [9];

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               deg;
    } t_normal;

    typedef struct {
        t_coords c;
        bit      typed;
        t_normal want;
    } t_row;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int LONG_HOLD      = 400;
    localparam int PHASE_ITEMS    = 630;

    logic clk;
    logic rst_n;

    tfn_in_if  #(.W(16)) tri_if ();
    tfn_out_if #(.W(16)) nrm_if ();

    triangle_face_normal u_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_tri  (tri_if),
        .o_nrm  (nrm_if)
    );

    t_normal normal_q[$];
    t_row    rows[$];
    int      mismatches = 0;
    int      src_idle;
    int      snk_idle;
    bit      hold_req;
    bit      failed = 1'b0;
    int      quiet_cycles;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int bit_length(bit [63:0] v);
        int n;
        n = 0;
        while (v != 0) begin
            n++;
            v = v >> 1;
        end
        return n;
    endfunction

    function automatic bit [63:0] int_sqrt(bit [63:0] t);
        bit [63:0] res;
        bit [63:0] one;
        res = 0;
        one = 64'd1 << 62;
        while (one > t) one = one >> 2;
        while (one != 0) begin
            if (t >= res + one) begin
                t   = t - (res + one);
                res = (res >> 1) + one;
            end else begin
                res = res >> 1;
            end
            one = one >> 2;
        end
        return res;
    endfunction

    // exact cross product e2 x e1, normalized magnitudes, rounded division by the length
    function automatic t_normal face_normal(t_coords c);
        longint    e1[3];
        longint    e2[3];
        longint    n[3];
        bit [63:0] mag[3];
        bit [63:0] a[3];
        bit [63:0] len2;
        bit [63:0] r;
        bit [63:0] q;
        bit        neg[3];
        int        b;
        int        bl;
        t_normal   res;
        for (int i = 0; i < 3; i++) begin
            e1[i] = longint'(c[3+i]) - longint'(c[i]);
            e2[i] = longint'(c[6+i]) - longint'(c[i]);
        end
        n[0] = e2[1] * e1[2] - e2[2] * e1[1];
        n[1] = e2[2] * e1[0] - e2[0] * e1[2];
        n[2] = e2[0] * e1[1] - e2[1] * e1[0];
        b = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = n[i] < 0;
            mag[i] = neg[i] ? -n[i] : n[i];
            bl = bit_length(mag[i]);
            if (bl > b) b = bl;
        end
        if (b == 0) begin
            res = '{x: 0, y: 0, z: 0, deg: 1'b1};
            return res;
        end
        len2 = 0;
        for (int i = 0; i < 3; i++) begin
            a[i] = (b <= NORM_BITS) ? mag[i] << (NORM_BITS - b) : mag[i] >> (b - NORM_BITS);
            len2 += a[i] * a[i];
        end
        r = int_sqrt(len2 << (2 * LEN_FRAC));
        for (int i = 0; i < 3; i++) begin
            q = ((a[i] << (14 + LEN_FRAC)) + (r >> 1)) / r;
            if (q > 64'd16384) q = 64'd16384;
            if (neg[i]) q = -q;
            case (i)
                0: res.x = q[15:0];
                1: res.y = q[15:0];
                default: res.z = q[15:0];
            endcase
        end
        res.deg = 1'b0;
        return res;
    endfunction

    function automatic logic signed [15:0] rnd_word();
        return 16'($urandom_range(16'hffff, 0));
    endfunction

    // offset kept inside the coordinate range
    function automatic logic signed [15:0] nudge(logic signed [15:0] base, int spread);
        int v;
        v = int'(base) + $urandom_range(2 * spread, 0) - spread;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic t_coords random_tri();
        t_coords c;
        int      kind;
        int      spread;
        int      k;
        int      d[3];
        kind = $urandom_range(9, 0);
        for (int i = 0; i < 9; i++) c[i] = rnd_word();
        if (kind < 4) begin
            // compact triangle around a random origin
            spread = 1 << $urandom_range(14, 0);
            for (int i = 3; i < 9; i++) c[i] = nudge(c[i % 3], spread);
        end else if (kind < 6) begin
            // collinear vertices, always a zero cross product
            for (int i = 0; i < 3; i++) begin
                d[i] = $urandom_range(200, 0) - 100;
                c[i] = 16'($urandom_range(8000, 0) - 4000);
            end
            k = $urandom_range(40, 0) - 20;
            for (int i = 0; i < 3; i++) begin
                c[3+i] = 16'(int'(c[i]) + d[i]);
                c[6+i] = 16'(int'(c[i]) + k * d[i]);
            end
        end else if (kind == 6) begin
            // repeated vertex
            for (int i = 0; i < 3; i++) c[3 + 3 * $urandom_range(1, 0) + i] = c[i];
        end else if (kind == 7) begin
            // extreme corners only
            for (int i = 0; i < 9; i++) c[i] = $urandom_range(1, 0) ? 16'sh7fff : 16'sh8000;
        end
        return c;
    endfunction

    task automatic add_row(t_coords c, bit typed, t_normal want);
        t_row row;
        row.c     = c;
        row.typed = typed;
        row.want  = want;
        rows.push_back(row);
    endtask

    task automatic send_tri(t_coords c, bit typed, t_normal want);
        while ($urandom_range(99, 0) < src_idle) begin
            tri_if.valid <= 1'b0;
            @(posedge clk);
        end
        tri_if.valid    <= 1'b1;
        tri_if.first_x  <= c[0];
        tri_if.first_y  <= c[1];
        tri_if.first_z  <= c[2];
        tri_if.second_x <= c[3];
        tri_if.second_y <= c[4];
        tri_if.second_z <= c[5];
        tri_if.third_x  <= c[6];
        tri_if.third_y  <= c[7];
        tri_if.third_z  <= c[8];
        @(posedge clk);
        while (!tri_if.ready) @(posedge clk);
        normal_q.push_back(typed ? want : face_normal(c));
    endtask

    // receiver: random back-pressure, with one long hold on request
    initial begin
        nrm_if.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                nrm_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
            end
            nrm_if.ready <= ($urandom_range(99, 0) >= snk_idle);
        end
    end

    // result check and watchdog
    always @(posedge clk) begin
        t_normal want;
        if (!rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if ((tri_if.valid && tri_if.ready) || (nrm_if.valid && nrm_if.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (nrm_if.valid && nrm_if.ready) begin
                if (normal_q.size() == 0) begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result transfer");
                end else begin
                    want = normal_q.pop_front();
                    if (nrm_if.normal_x !== want.x || nrm_if.normal_y !== want.y ||
                        nrm_if.normal_z !== want.z || nrm_if.degenerate !== want.deg) begin
                        failed = 1'b1;
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: want %0d %0d %0d deg %0b, got %0d %0d %0d deg %0b",
                                     want.x, want.y, want.z, want.deg, nrm_if.normal_x,
                                     nrm_if.normal_y, nrm_if.normal_z, nrm_if.degenerate);
                    end
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        t_coords c;
        t_normal none;
        t_normal want;
        hold_req     = 1'b0;
        src_idle     = 16;
        snk_idle     = 80;
        none         = '{x: 0, y: 0, z: 0, deg: 1'b0};
        rst_n        = 1'b0;
        tri_if.valid = 1'b0;
        tri_if.first_x  = '0;
        tri_if.first_y  = '0;
        tri_if.first_z  = '0;
        tri_if.second_x = '0;
        tri_if.second_y = '0;
        tri_if.second_z = '0;
        tri_if.third_x  = '0;
        tri_if.third_y  = '0;
        tri_if.third_z  = '0;

        // all vertices at the origin: zero cross product
        c = '{default: 16'sd0};
        add_row(c, 1'b1, '{x: 0, y: 0, z: 0, deg: 1'b1});
        // unit edges along x then y: normal points down z
        c = '{0, 0, 0, 256, 0, 0, 0, 256, 0};
        add_row(c, 1'b1, '{x: 0, y: 0, z: -16384, deg: 1'b0});
        c = '{0, 0, 0, 0, 256, 0, 0, 0, 256};
        add_row(c, 1'b1, '{x: -16384, y: 0, z: 0, deg: 1'b0});
        c = '{0, 0, 0, 0, 0, 256, 256, 0, 0};
        add_row(c, 1'b1, '{x: 0, y: -16384, z: 0, deg: 1'b0});
        c = '{0, 0, 0, 0, 256, 0, 256, 0, 0};
        add_row(c, 1'b1, '{x: 0, y: 0, z: 16384, deg: 1'b0});
        // collinear and repeated vertices
        c = '{10, 20, 30, 20, 40, 60, 40, 80, 120};
        add_row(c, 1'b1, '{x: 0, y: 0, z: 0, deg: 1'b1});
        c = '{-32768, -32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767};
        add_row(c, 1'b1, '{x: 0, y: 0, z: 0, deg: 1'b1});
        c = '{32767, -32768, 5, 32767, -32768, 5, 1, 2, 3};
        add_row(c, 1'b1, '{x: 0, y: 0, z: 0, deg: 1'b1});
        // full-range extremes, largest cross products
        c = '{-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768};
        add_row(c, 1'b0, none);
        c = '{32767, 32767, 32767, -32768, 32767, -32768, 32767, -32768, -32768};
        add_row(c, 1'b0, none);
        c = '{-32768, 32767, -32768, 32767, 32767, 32767, -32768, -32768, 32767};
        add_row(c, 1'b0, none);
        c = '{32767, -32768, 0, -32768, 32767, 32767, 0, 0, -32768};
        add_row(c, 1'b0, none);
        // smallest nonzero normal and near-equal components (rounding toward one)
        c = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
        add_row(c, 1'b0, none);
        c = '{0, 0, 0, 1, 1, 0, 0, 1, 1};
        add_row(c, 1'b0, none);
        c = '{0, 0, 0, 256, 1, 0, 0, 256, 0};
        add_row(c, 1'b0, none);
        c = '{-1, -1, -1, -1, 0, -2, 3, -1, -1};
        add_row(c, 1'b0, none);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i]) send_tri(rows[i].c, rows[i].typed, rows[i].want);

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                src_idle = 80;
                snk_idle = 16;
            end else if (phase == 2) begin
                src_idle = 0;
                snk_idle = 0;
                // sender waits for the pipeline to drain, then floods a stalled receiver
                tri_if.valid <= 1'b0;
                wait (normal_q.size() == 0);
                @(posedge clk);
                hold_req = 1'b1;
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                c = random_tri();
                send_tri(c, 1'b0, none);
            end
        end
        tri_if.valid <= 1'b0;

        wait (normal_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (!failed && normal_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
